@@ rtl/core/sts_hdp_pkg.sv @@
// Shared types, character constants and name tables for the
// Strict-Transport-Security header directive parser. No dependencies.
package sts_hdp_pkg;

    // Directive parse phase
    typedef enum logic [4:0] {
        PH_LEAD      = 5'b00001,
        PH_NAME      = 5'b00010,
        PH_SKIP_LEAD = 5'b00100,
        PH_SKIP      = 5'b01000,
        PH_NUM       = 5'b10000
    } t_phase;

    // max-age value sub-state
    typedef enum logic [4:0] {
        NS_LEAD   = 5'b00001,
        NS_SIGN   = 5'b00010,
        NS_DIGITS = 5'b00100,
        NS_TRAIL  = 5'b01000,
        NS_JUNK   = 5'b10000
    } t_num;

    // Running control state of the parser (the age values travel apart,
    // their width follows the top-level parameter)
    typedef struct packed {
        t_phase     phase;
        logic [4:0] name_len;
        logic       match_age;
        logic       match_sub;
        logic       space_seen;
        t_num       num;
        logic       neg;
        logic       age_held;
        logic       neg_held;
        logic       sub_seen;
        logic       failed;
        logic       stopped;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        phase:      PH_LEAD,
        name_len:   5'd0,
        match_age:  1'b1,
        match_sub:  1'b1,
        space_seen: 1'b0,
        num:        NS_LEAD,
        neg:        1'b0,
        age_held:   1'b0,
        neg_held:   1'b0,
        sub_seen:   1'b0,
        failed:     1'b0,
        stopped:    1'b0
    };

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CTRL  = 8'h20;   // bytes below this are control

    localparam logic [4:0] LEN_AGE  = 5'd7;
    localparam logic [4:0] LEN_SUB  = 5'd17;
    localparam logic [4:0] LEN_MAX  = 5'd31;

    localparam logic [3:0] DEC_BASE = 4'd10;

    localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

    // Space and TAB..CR
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // "max-age", lower case
    function automatic logic [7:0] char_age(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6D;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h78;
            3'd3:    ch = 8'h2D;
            3'd4:    ch = 8'h61;
            3'd5:    ch = 8'h67;
            3'd6:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "includesubdomains", lower case
    function automatic logic [7:0] char_sub(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h69;
            5'd1:    ch = 8'h6E;
            5'd2:    ch = 8'h63;
            5'd3:    ch = 8'h6C;
            5'd4:    ch = 8'h75;
            5'd5:    ch = 8'h64;
            5'd6:    ch = 8'h65;
            5'd7:    ch = 8'h73;
            5'd8:    ch = 8'h75;
            5'd9:    ch = 8'h62;
            5'd10:   ch = 8'h64;
            5'd11:   ch = 8'h6F;
            5'd12:   ch = 8'h6D;
            5'd13:   ch = 8'h61;
            5'd14:   ch = 8'h69;
            5'd15:   ch = 8'h6E;
            5'd16:   ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/sts_hdp_feed.sv @@
// One character step of the directive parser: next parse state from the
// current state and one byte. Purely combinational. Uses sts_hdp_pkg.
module sts_hdp_feed #(
    parameter int AGE_BITS = 31
) (
    input  sts_hdp_pkg::t_ctl    i_ctl,
    input  logic [AGE_BITS-1:0]  i_acc,
    input  logic [AGE_BITS-1:0]  i_age,
    input  logic [7:0]           i_char,
    output sts_hdp_pkg::t_ctl    o_ctl,
    output logic [AGE_BITS-1:0]  o_acc,
    output logic [AGE_BITS-1:0]  o_age
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam int PW = AGE_BITS + 4;

    sts_hdp_pkg::t_ctl    ctl;
    sts_hdp_pkg::t_phase  ph;
    sts_hdp_pkg::t_num    sub;
    logic                 go;
    logic                 do_end;
    logic                 has_val;
    logic                 do_fin;
    logic                 do_begin;
    logic                 do_stop;
    logic                 is_age;
    logic                 is_sub;
    logic                 whole;
    logic                 neg_val;
    logic                 digit;
    logic [7:0]           lc;
    logic [PW-1:0]        prod;
    logic [AGE_BITS-1:0]  acc;
    logic [AGE_BITS-1:0]  age;

    // acc * 10 + digit, checked against the saturation limit
    assign prod = ({4'd0, i_acc} << 3) + ({4'd0, i_acc} << 1)
                + PW'(i_char - sts_hdp_pkg::CH_ZERO);

    always_comb begin
        ctl      = i_ctl;
        acc      = i_acc;
        age      = i_age;
        ph       = i_ctl.phase;
        sub      = i_ctl.num;
        go       = 1'b0;
        do_end   = 1'b0;
        has_val  = 1'b0;
        do_fin   = 1'b0;
        do_begin = 1'b0;
        do_stop  = 1'b0;
        lc       = sts_hdp_pkg::to_lower(i_char);
        digit    = (i_char >= sts_hdp_pkg::CH_ZERO) && (i_char <= sts_hdp_pkg::CH_NINE);
        is_age   = i_ctl.match_age && (i_ctl.name_len == sts_hdp_pkg::LEN_AGE);
        is_sub   = i_ctl.match_sub && (i_ctl.name_len == sts_hdp_pkg::LEN_SUB);
        whole    = (i_ctl.num == sts_hdp_pkg::NS_DIGITS) || (i_ctl.num == sts_hdp_pkg::NS_TRAIL);
        neg_val  = i_ctl.neg && (i_acc != '0);

        if (!i_ctl.failed && !i_ctl.stopped) begin
            go = 1'b1;
            // leading whitespace before a name or a skipped value
            if (ph == sts_hdp_pkg::PH_LEAD) begin
                if (sts_hdp_pkg::is_ws(i_char)) begin
                    go = 1'b0;
                end else begin
                    ph = sts_hdp_pkg::PH_NAME;
                end
            end else if (ph == sts_hdp_pkg::PH_SKIP_LEAD) begin
                if (sts_hdp_pkg::is_ws(i_char)) begin
                    go = 1'b0;
                end else begin
                    ph = sts_hdp_pkg::PH_SKIP;
                end
            end
        end

        if (go) begin
            ctl.phase = ph;
            unique case (ph)
                sts_hdp_pkg::PH_NAME: begin
                    if (i_char < sts_hdp_pkg::CH_CTRL || i_char == sts_hdp_pkg::CH_COMMA) begin
                        do_end  = 1'b1;
                        do_stop = 1'b1;
                    end else if (i_char == sts_hdp_pkg::CH_SEMI) begin
                        do_end   = 1'b1;
                        do_begin = 1'b1;
                    end else if (i_char == sts_hdp_pkg::CH_EQ) begin
                        do_end  = 1'b1;
                        has_val = 1'b1;
                    end else if (i_char == sts_hdp_pkg::CH_SPACE) begin
                        ctl.space_seen = 1'b1;
                    end else if (i_ctl.space_seen) begin
                        ctl.match_age = 1'b0;
                        ctl.match_sub = 1'b0;
                    end else begin
                        if (i_ctl.name_len >= sts_hdp_pkg::LEN_AGE
                            || sts_hdp_pkg::char_age(i_ctl.name_len[2:0]) != lc) begin
                            ctl.match_age = 1'b0;
                        end
                        if (i_ctl.name_len >= sts_hdp_pkg::LEN_SUB
                            || sts_hdp_pkg::char_sub(i_ctl.name_len) != lc) begin
                            ctl.match_sub = 1'b0;
                        end
                        if (i_ctl.name_len < sts_hdp_pkg::LEN_MAX) begin
                            ctl.name_len = i_ctl.name_len + 5'd1;
                        end
                    end
                end
                sts_hdp_pkg::PH_SKIP: begin
                    if (i_char == sts_hdp_pkg::CH_SEMI) begin
                        do_begin = 1'b1;
                    end else if (i_char < sts_hdp_pkg::CH_CTRL) begin
                        do_stop = 1'b1;
                    end
                end
                sts_hdp_pkg::PH_NUM: begin
                    if (i_ctl.num == sts_hdp_pkg::NS_LEAD && sts_hdp_pkg::is_ws(i_char)) begin
                        // skip whitespace before the value
                    end else if (i_char == sts_hdp_pkg::CH_SEMI) begin
                        do_fin   = 1'b1;
                        do_begin = 1'b1;
                    end else if (i_char < sts_hdp_pkg::CH_CTRL) begin
                        do_fin  = 1'b1;
                        do_stop = 1'b1;
                    end else begin
                        if (digit && (i_ctl.num == sts_hdp_pkg::NS_LEAD
                                      || i_ctl.num == sts_hdp_pkg::NS_SIGN
                                      || i_ctl.num == sts_hdp_pkg::NS_DIGITS)) begin
                            acc = (prod > PW'(AGE_MAX)) ? AGE_MAX : prod[AGE_BITS-1:0];
                            sub = sts_hdp_pkg::NS_DIGITS;
                        end else if (i_ctl.num == sts_hdp_pkg::NS_LEAD
                                     && (i_char == sts_hdp_pkg::CH_PLUS
                                         || i_char == sts_hdp_pkg::CH_MINUS)) begin
                            sub = sts_hdp_pkg::NS_SIGN;
                            if (i_char == sts_hdp_pkg::CH_MINUS) begin
                                ctl.neg = 1'b1;
                            end
                        end else if (whole && i_char == sts_hdp_pkg::CH_SPACE) begin
                            sub = sts_hdp_pkg::NS_TRAIL;
                        end else begin
                            sub = sts_hdp_pkg::NS_JUNK;
                        end
                        ctl.num = sub;
                    end
                end
                default: begin
                    ctl.stopped = 1'b1;
                end
            endcase
        end

        // name complete: act on the recognized directive
        if (do_end) begin
            if (is_age && has_val) begin
                if (i_ctl.age_held) begin
                    ctl.failed = 1'b1;
                end else begin
                    ctl.phase = sts_hdp_pkg::PH_NUM;
                    ctl.num   = sts_hdp_pkg::NS_LEAD;
                    ctl.neg   = 1'b0;
                    acc       = '0;
                end
            end else if (is_sub) begin
                if (i_ctl.sub_seen || has_val) begin
                    ctl.failed = 1'b1;
                end else begin
                    ctl.sub_seen = 1'b1;
                end
            end else if (has_val) begin
                ctl.phase = sts_hdp_pkg::PH_SKIP_LEAD;
            end
        end

        // value complete: store or reject the age
        if (do_fin) begin
            if (neg_val && whole) begin
                ctl.failed = 1'b1;
            end else if (neg_val) begin
                ctl.age_held = 1'b0;
                ctl.neg_held = 1'b1;
                age          = '0;
            end else begin
                ctl.age_held = 1'b1;
                ctl.neg_held = 1'b0;
                age          = i_acc;
            end
        end

        // next directive
        if (do_begin) begin
            ctl.phase      = sts_hdp_pkg::PH_LEAD;
            ctl.name_len   = 5'd0;
            ctl.match_age  = 1'b1;
            ctl.match_sub  = 1'b1;
            ctl.space_seen = 1'b0;
        end

        if (do_stop) begin
            ctl.stopped = 1'b1;
        end
    end

    assign o_ctl = ctl;
    assign o_acc = acc;
    assign o_age = age;

endmodule

@@ rtl/core/sts_hdp_top_unused_placeholder.sv @@
// Result formatter: saturates the stored age to 31 bits and packs the
// result word. Combinational. Uses sts_hdp_pkg.
module sts_hdp_result #(
    parameter int AGE_BITS = 31
) (
    input  sts_hdp_pkg::t_ctl    i_ctl,
    input  logic [AGE_BITS-1:0]  i_age,
    output logic [39:0]          o_word
);

    localparam int WB = (AGE_BITS > 31) ? AGE_BITS : 31;

    logic [WB-1:0] age_ext;
    logic [30:0]   age_sat;
    logic          ok;

    assign age_ext = WB'(i_age);
    assign age_sat = (age_ext > WB'(sts_hdp_pkg::OUT_MAX)) ? sts_hdp_pkg::OUT_MAX
                                                           : age_ext[30:0];
    assign ok      = !i_ctl.failed && i_ctl.age_held;

    // fields from bit 0: policy_valid, max_age[30:0], include_subdomains
    assign o_word = {7'd0, ok && i_ctl.sub_seen, ok ? age_sat : 31'd0, ok};

endmodule

@@ rtl/core/sts_header_directive_parser_unit.sv @@
// Top level of the Strict-Transport-Security header directive parser.
// Depends on sts_hdp_pkg, sts_hdp_feed and sts_hdp_result.
//
// The block takes one header character per word and accepts a word in every
// cycle. A character word is held in the input register, then stepped through
// the parser; the final character (tlast) is followed in the same cycle by the
// end-of-string step, and the result word is registered in the output
// register. The only stall is on a final character while the previous result
// word still waits in the output register. After each result the parser
// returns to its reset state for the next header.
module sts_header_directive_parser_unit #(
    parameter int AGE_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_byte
    input  logic        i_s_axis_tlast,   // last_char
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [0] policy_valid, [31:1] max_age,
                                          // [32] include_subdomains, rest zero
);

    logic                 r_in_valid;
    logic [7:0]           r_char;
    logic                 r_last;
    sts_hdp_pkg::t_ctl    r_ctl;
    logic [AGE_BITS-1:0]  r_acc;
    logic [AGE_BITS-1:0]  r_age;
    logic                 r_out_valid;
    logic [39:0]          r_out_word;

    sts_hdp_pkg::t_ctl    n_ctl;
    logic [AGE_BITS-1:0]  n_acc;
    logic [AGE_BITS-1:0]  n_age;
    sts_hdp_pkg::t_ctl    end_ctl;
    logic [AGE_BITS-1:0]  end_acc;
    logic [AGE_BITS-1:0]  end_age;
    logic [39:0]          n_out_word;
    logic                 proc;

    // step the registered word now unless it is final and the result slot is busy
    assign proc            = r_in_valid && (!r_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc;

    // character step, then end-of-string step for the final word
    sts_hdp_feed #(.AGE_BITS(AGE_BITS)) u_feed_char (
        .i_ctl  (r_ctl),
        .i_acc  (r_acc),
        .i_age  (r_age),
        .i_char (r_char),
        .o_ctl  (n_ctl),
        .o_acc  (n_acc),
        .o_age  (n_age)
    );

    sts_hdp_feed #(.AGE_BITS(AGE_BITS)) u_feed_end (
        .i_ctl  (n_ctl),
        .i_acc  (n_acc),
        .i_age  (n_age),
        .i_char (8'h00),
        .o_ctl  (end_ctl),
        .o_acc  (end_acc),
        .o_age  (end_age)
    );

    sts_hdp_result #(.AGE_BITS(AGE_BITS)) u_result (
        .i_ctl  (end_ctl),
        .i_age  (end_age),
        .o_word (n_out_word)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_char <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= sts_hdp_pkg::CTL_RESET;
            r_acc <= '0;
            r_age <= '0;
        end else if (proc) begin
            if (r_last) begin
                r_ctl <= sts_hdp_pkg::CTL_RESET;
                r_acc <= '0;
                r_age <= '0;
            end else begin
                r_ctl <= n_ctl;
                r_acc <= n_acc;
                r_age <= n_age;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_last) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_word;

endmodule

@@ verif/sts_hdp_policy_checker.sv @@
`timescale 1ns / 1ps
// Policy checker for the STS header directive parser: follows both stream ports,
// predicts each policy word from the accepted characters and compares. Needs sts_hdp_pkg.
module sts_hdp_policy_checker
    import sts_hdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_word,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [55:0]  AGE_WORD  = "max-age";
    localparam logic [135:0] SUB_WORD  = "includesubdomains";
    localparam logic [63:0]  AGE_LIMIT = 64'h7FFF_FFFF;

    typedef struct packed {
        logic        ok;
        logic [30:0] age;
        logic        sub;
    } t_policy;

    t_policy     policy_q[$];
    int          bad_count = 0;

    // Running parse state
    t_phase      phase;
    logic [4:0]  name_len;
    logic        hit_age, hit_sub, name_gap;
    logic [63:0] digits_acc;
    t_num        num_st;
    logic        minus;
    logic [63:0] kept_age;
    logic        have_age, sub_flag, failed, stopped;

    function automatic logic blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Letter idx of an n-letter name packed first letter high
    function automatic logic [7:0] letter(input logic [135:0] w, input int n, input int idx);
        return w[8*(n-1-idx) +: 8];
    endfunction

    task automatic start_directive();
        phase    = PH_LEAD;
        name_len = '0;
        hit_age  = 1'b1;
        hit_sub  = 1'b1;
        name_gap = 1'b0;
    endtask

    task automatic clear_all();
        start_directive();
        digits_acc = '0;
        num_st     = NS_LEAD;
        minus      = 1'b0;
        kept_age   = '0;
        have_age   = 1'b0;
        sub_flag   = 1'b0;
        failed     = 1'b0;
        stopped    = 1'b0;
    endtask

    // A name is complete; decide what it was
    task automatic close_name(input logic valued);
        logic is_age, is_sub;
        is_age = hit_age && name_len == LEN_AGE;
        is_sub = hit_sub && name_len == LEN_SUB;
        if (is_age && valued) begin
            if (have_age) begin
                failed = 1'b1;
            end else begin
                phase      = PH_NUM;
                num_st     = NS_LEAD;
                minus      = 1'b0;
                digits_acc = '0;
            end
        end else if (is_sub) begin
            if (sub_flag || valued)
                failed = 1'b1;
            else
                sub_flag = 1'b1;
        end else if (valued) begin
            phase = PH_SKIP_LEAD;
        end
    endtask

    // A max-age value is complete
    task automatic close_number();
        logic whole, neg;
        whole = num_st == NS_DIGITS || num_st == NS_TRAIL;
        neg   = minus && digits_acc != 0;
        if (neg && whole) begin
            failed = 1'b1;
        end else if (neg) begin
            // negative with trailing junk: age treated as absent
            have_age = 1'b0;
            kept_age = '0;
        end else begin
            have_age = 1'b1;
            kept_age = digits_acc;
        end
    endtask

    task automatic name_step(input logic [7:0] c);
        logic [7:0] lc;
        if (c < CH_CTRL || c == CH_COMMA) begin
            close_name(1'b0);
            stopped = 1'b1;
        end else if (c == CH_SEMI) begin
            close_name(1'b0);
            start_directive();
        end else if (c == CH_EQ) begin
            close_name(1'b1);
        end else if (c == CH_SPACE) begin
            name_gap = 1'b1;
        end else if (name_gap) begin
            // text after an inner space: matches nothing
            hit_age = 1'b0;
            hit_sub = 1'b0;
        end else begin
            lc = lower(c);
            if (name_len >= LEN_AGE || letter({80'd0, AGE_WORD}, 7, name_len) != lc)
                hit_age = 1'b0;
            if (name_len >= LEN_SUB || letter(SUB_WORD, 17, name_len) != lc)
                hit_sub = 1'b0;
            if (name_len < LEN_MAX)
                name_len = name_len + 1'b1;
        end
    endtask

    task automatic number_step(input logic [7:0] c);
        logic [63:0] d;
        if (num_st == NS_LEAD && blank(c))
            return;
        if (c == CH_SEMI) begin
            close_number();
            start_directive();
            return;
        end
        if (c < CH_CTRL) begin
            close_number();
            stopped = 1'b1;
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE && num_st inside {NS_LEAD, NS_SIGN, NS_DIGITS}) begin
            d = 64'(c - CH_ZERO);
            if (digits_acc > (AGE_LIMIT - d) / 10)
                digits_acc = AGE_LIMIT;
            else
                digits_acc = digits_acc * 10 + d;
            num_st = NS_DIGITS;
        end else if (num_st == NS_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
            num_st = NS_SIGN;
            if (c == CH_MINUS)
                minus = 1'b1;
        end else if ((num_st == NS_DIGITS || num_st == NS_TRAIL) && c == CH_SPACE) begin
            num_st = NS_TRAIL;
        end else begin
            num_st = NS_JUNK;
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        if (failed || stopped)
            return;
        if (phase == PH_LEAD) begin
            if (blank(c))
                return;
            phase = PH_NAME;
        end
        if (phase == PH_SKIP_LEAD) begin
            if (blank(c))
                return;
            phase = PH_SKIP;
        end
        if (phase == PH_NAME) begin
            name_step(c);
        end else if (phase == PH_SKIP) begin
            if (c == CH_SEMI)
                start_directive();
            else if (c < CH_CTRL)
                stopped = 1'b1;
        end else if (phase == PH_NUM) begin
            number_step(c);
        end else begin
            stopped = 1'b1;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            bad_count++;
            if (bad_count <= 10)
                $display("mismatch %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // Follow both ports; result words are checked before new characters are scanned
    always @(posedge i_clk) begin
        t_policy want;
        if (!i_rst_n) begin
            clear_all();
            policy_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (policy_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result word %0h", i_out_word);
                end else begin
                    want = policy_q.pop_front();
                    check_field("policy_valid", 32'(want.ok), 32'(i_out_word[0]));
                    check_field("max_age", 32'(want.age), 32'(i_out_word[31:1]));
                    check_field("include_subdomains", 32'(want.sub), 32'(i_out_word[32]));
                    check_field("padding", 32'd0, 32'(i_out_word[39:33]));
                end
            end
            if (i_in_valid && i_in_ready) begin
                scan_char(i_in_char);
                if (i_in_last) begin
                    // end of string closes whatever is open
                    scan_char(8'h00);
                    want.ok  = !failed && have_age;
                    want.age = want.ok ? kept_age[30:0] : '0;
                    want.sub = want.ok && sub_flag;
                    policy_q.push_back(want);
                    clear_all();
                end
            end
        end
        o_errors  = bad_count;
        o_pending = policy_q.size();
    end

endmodule

@@ verif/sts_header_directive_parser_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for sts_header_directive_parser_unit: drives header characters and
// random output stalls, gives the verdict. Needs sts_hdp_pkg and sts_hdp_policy_checker.
module sts_header_directive_parser_unit_test;
    import sts_hdp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_GOAL   = 1300;
    localparam int CALM_AT     = 1100;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'h00;
    logic        s_last  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;   // [0] policy_valid, [31:1] max_age, [32] include_subdomains

    int          errors, pending;
    int          quiet       = 0;
    int          stall_left  = 0;
    int          items_sent  = 0;
    logic        calm        = 1'b0;
    logic [7:0]  hdr[$];

    always #4 clk = ~clk;

    sts_header_directive_parser_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    sts_hdp_policy_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_char   (s_data),
        .i_in_last   (s_last),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_word  (m_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Result side stalls in random bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(7) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: cycles without any accepted word
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            hdr.push_back(s[k]);
    endfunction

    // Name with random letter case
    function automatic void put_name(input string s);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if (c >= "a" && c <= "z" && $urandom_range(1))
                c = c - 8'd32;
            hdr.push_back(c);
        end
    endfunction

    function automatic void put_pad();
        repeat ($urandom_range(0, 2))
            hdr.push_back(($urandom_range(3) == 0) ? 8'h09 : CH_SPACE);
    endfunction

    function automatic void put_value();
        int n;
        n = $urandom_range(0, 5);
        repeat (n)
            hdr.push_back(8'($urandom_range(33, 126)));
    endfunction

    // One random directive, mostly well formed
    function automatic void put_directive();
        int n;
        put_pad();
        case ($urandom_range(5))
            0, 1, 2: begin
                case ($urandom_range(9))
                    0:       put_name("max-ag");
                    1:       put_name("max-agee");
                    default: put_name("max-age");
                endcase
                if ($urandom_range(7) != 0) begin
                    put_pad();
                    hdr.push_back(CH_EQ);
                    put_pad();
                    case ($urandom_range(5))
                        0:       hdr.push_back(CH_MINUS);
                        1:       hdr.push_back(CH_PLUS);
                        default: ;
                    endcase
                    n = ($urandom_range(4) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
                    repeat (n)
                        hdr.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                    if ($urandom_range(4) == 0)
                        put_value();
                end
            end
            3: begin
                if ($urandom_range(9) == 0)
                    put_name("includesubdomain");
                else
                    put_name("includesubdomains");
                if ($urandom_range(6) == 0) begin
                    hdr.push_back(CH_EQ);
                    put_value();
                end
            end
            4: begin
                n = $urandom_range(1, 8);
                repeat (n)
                    hdr.push_back(8'($urandom_range("a", "z")));
                if ($urandom_range(1)) begin
                    hdr.push_back(CH_EQ);
                    put_pad();
                    put_value();
                end
            end
            default: ;
        endcase
        put_pad();
    endfunction

    function automatic void make_random_header();
        int n, kind, idx;
        kind = $urandom_range(99);
        if (kind < 13) begin
            // raw noise over the whole byte range
            n = $urandom_range(1, 16);
            repeat (n)
                hdr.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                if (k > 0)
                    hdr.push_back(CH_SEMI);
                put_directive();
            end
            if ($urandom_range(3) == 0)
                hdr.push_back(CH_SEMI);
            if (hdr.size() == 0)
                hdr.push_back(CH_SPACE);
            // broken header: one byte replaced by a control, comma or '='
            if (kind < 25) begin
                idx = $urandom_range(0, hdr.size() - 1);
                case ($urandom_range(2))
                    0:       hdr[idx] = 8'($urandom_range(0, 31));
                    1:       hdr[idx] = CH_COMMA;
                    default: hdr[idx] = CH_EQ;
                endcase
            end
        end
    endfunction

    // Present one character word, with an occasional gap before it
    task automatic send_char(input logic [7:0] c, input logic is_last);
        logic go;
        if (!calm && $urandom_range(5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= is_last;
        do begin
            @(negedge clk);
            go = s_ready;
            @(posedge clk);
        end while (!go);
        items_sent++;
        if (items_sent >= CALM_AT)
            calm = 1'b1;
    endtask

    task automatic send_header();
        if (hdr.size() == 0)
            hdr.push_back(CH_SPACE);
        for (int k = 0; k < hdr.size(); k++)
            send_char(hdr[k], k == hdr.size() - 1);
        hdr.delete();
    endtask

    // Hold the sender until every expected policy word has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial begin
        logic paused;
        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed headers
        put_text("max-age=31536000; includeSubDomains"); send_header();
        put_text("MAX-AGE=0"); send_header();
        put_text("  max-age = 99999999999 ;\tINCLUDESUBDOMAINS  "); send_header();
        put_text("max-age=2147483647"); send_header();
        put_text("max-age=2147483648"); send_header();
        put_text("max-age="); send_header();
        put_text("max-age=-0"); send_header();
        put_text("max-age=-5"); send_header();
        put_text("max-age=-5x"); send_header();
        put_text("max-age=-5x; max-age=7"); send_header();
        put_text("max-age=  -12 3"); send_header();
        put_text("max-age=+42  ;"); send_header();
        put_text("max-age=5; max-age=6"); send_header();
        put_text("max-age=5; includeSubDomains; includesubdomains"); send_header();
        put_text("includeSubDomains=1; max-age=5"); send_header();
        put_text("includeSubDomains"); send_header();
        put_text("max-age; foo=bar; max-age=12"); send_header();
        put_text("max age=5"); send_header();
        put_text("max-age=9; includeSubDomains,junk"); send_header();
        put_text("max-age=3"); hdr.push_back(8'h01);
        put_text("; includeSubDomains"); send_header();
        put_text("max-age=4;"); hdr.push_back(8'h00);
        put_text("includeSubDomains"); send_header();
        put_text("max-age=8; "); hdr.push_back(8'hC3); hdr.push_back(8'hA9);
        put_text("x=1"); send_header();
        put_text("includeSubDomainsincludeSubDomainsXX; max-age=1"); send_header();
        put_text("foo=ba"); hdr.push_back(8'h1F); put_text("r; max-age=1"); send_header();
        put_text("max-age=1;;; ;includeSubDomains;"); send_header();
        put_text(";"); send_header();
        drain();

        // Random headers
        while (items_sent < ITEM_GOAL) begin
            make_random_header();
            send_header();
            if (!paused && items_sent >= ITEM_GOAL / 2) begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
